// ----- rtl/ddo_pkg.sv -----
// Shared constants, command types and the arctangent table for the odometry block.
`timescale 1ns / 1ps
package ddo_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int DIV_BITS         = 49;   // dividend is |r - l| << 16
    localparam int CNT_W            = 6;
    localparam int PADDR_W          = 3;

    localparam logic [31:0] AXLE_RESET = 32'd43909;
    localparam logic [0:0]  REG_AXLE   = 1'b0;

    localparam logic signed [33:0] GAIN_Q31   = 34'sd1304065748;
    localparam logic signed [33:0] RAD_TO_BAM = 34'sd683565276;

    localparam logic signed [49:0] POS_MAX = 50'sd140737488355327;
    localparam logic signed [49:0] POS_MIN = -50'sd140737488355328;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV,
        OP_WSAT,
        OP_MULW,
        OP_MULL,
        OP_MULH,
        OP_DTH,
        OP_RPRE,
        OP_SCLX,
        OP_SCLY,
        OP_SCLW,
        OP_ROT,
        OP_RPOST,
        OP_MDX,
        OP_MDY,
        OP_DYWB,
        OP_COMMIT
    } ddo_op_t;

    typedef struct packed {
        ddo_op_t    op;
        logic [4:0] idx;    // CORDIC iteration
        logic       phase;  // 0: heading-change rotation, 1: world rotation
    } ddo_cmd_t;

    function automatic logic [31:0] atan_bam(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/ddo_ctrl.sv -----
// Sequencer for the odometry datapath: divide, multiply steps, two CORDIC passes, commit.
`timescale 1ns / 1ps
module ddo_ctrl import ddo_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output ddo_cmd_t cmd
);

    typedef enum logic [16:0] {
        ST_IDLE  = 17'h00001,
        ST_DIV   = 17'h00002,
        ST_WSAT  = 17'h00004,
        ST_MULW  = 17'h00008,
        ST_MULL  = 17'h00010,
        ST_MULH  = 17'h00020,
        ST_DTH   = 17'h00040,
        ST_RPRE  = 17'h00080,
        ST_SCLX  = 17'h00100,
        ST_SCLY  = 17'h00200,
        ST_SCLW  = 17'h00400,
        ST_ROT   = 17'h00800,
        ST_RPOST = 17'h01000,
        ST_MDX   = 17'h02000,
        ST_MDY   = 17'h04000,
        ST_DYWB  = 17'h08000,
        ST_DONE  = 17'h10000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             phase_reg, phase_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        cmd.op     = OP_NONE;
        cmd.idx    = cnt_reg[4:0];
        cmd.phase  = phase_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.op   = OP_DIV;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_BITS - 1)) state_next = ST_WSAT;
            end
            ST_WSAT: begin
                cmd.op     = OP_WSAT;
                state_next = ST_MULW;
            end
            ST_MULW: begin
                cmd.op     = OP_MULW;
                state_next = ST_MULL;
            end
            ST_MULL: begin
                cmd.op     = OP_MULL;
                state_next = ST_MULH;
            end
            ST_MULH: begin
                cmd.op     = OP_MULH;
                state_next = ST_DTH;
            end
            ST_DTH: begin
                cmd.op     = OP_DTH;
                phase_next = 1'b0;
                state_next = ST_RPRE;
            end
            ST_RPRE: begin
                cmd.op     = OP_RPRE;
                state_next = ST_SCLX;
            end
            ST_SCLX: begin
                cmd.op     = OP_SCLX;
                state_next = ST_SCLY;
            end
            ST_SCLY: begin
                cmd.op     = OP_SCLY;
                state_next = ST_SCLW;
            end
            ST_SCLW: begin
                cmd.op     = OP_SCLW;
                cnt_next   = '0;
                state_next = ST_ROT;
            end
            ST_ROT: begin
                cmd.op   = OP_ROT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1)) state_next = ST_RPOST;
            end
            ST_RPOST: begin
                cmd.op = OP_RPOST;
                if (!phase_reg) begin
                    phase_next = 1'b1;
                    state_next = ST_RPRE;
                end else begin
                    state_next = ST_MDX;
                end
            end
            ST_MDX: begin
                cmd.op     = OP_MDX;
                state_next = ST_MDY;
            end
            ST_MDY: begin
                cmd.op     = OP_MDY;
                state_next = ST_DYWB;
            end
            ST_DYWB: begin
                cmd.op     = OP_DYWB;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // wait here until the output register is free
                if (out_free) begin
                    cmd.op     = OP_COMMIT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.op == OP_COMMIT) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- rtl/ddo_dpath.sv -----
// Odometry datapath: divider, shared multiplier, CORDIC rotator and pose accumulators.
`timescale 1ns / 1ps
module ddo_dpath import ddo_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  ddo_cmd_t           cmd,
    input  logic [31:0]        axle_length,
    input  logic signed [31:0] s_left_speed,
    input  logic signed [31:0] s_right_speed,
    input  logic [23:0]        s_elapsed_time,
    output logic signed [47:0] m_pos_x,
    output logic signed [47:0] m_pos_y,
    output logic [31:0]        m_heading,
    output logic signed [31:0] m_vel_fwd,
    output logic signed [31:0] m_vel_side,
    output logic signed [31:0] m_turn_rate
);

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        logic signed [49:0] r;
        if (v > POS_MAX) begin
            r = POS_MAX;
        end else if (v < POS_MIN) begin
            r = POS_MIN;
        end else begin
            r = v;
        end
        return r[47:0];
    endfunction

    // item and intermediate registers
    logic signed [31:0] v_reg;
    logic               dneg_reg, dzero_reg;
    logic [23:0]        dt_reg;
    logic [31:0]        rem_reg;
    logic [48:0]        quo_reg;
    logic signed [31:0] w_reg;
    logic signed [67:0] prod_reg;
    logic [31:0]        ph_reg, acc_reg, dth_reg;
    logic signed [49:0] cx_reg, cy_reg;
    logic signed [33:0] z_reg;
    logic signed [31:0] vx_reg, vy_reg;
    logic signed [33:0] wx_reg, wy_reg;
    logic signed [47:0] nx_reg, ny_reg;
    logic signed [47:0] pose_x_reg, pose_y_reg;
    logic [31:0]        pose_h_reg;
    logic signed [31:0] out_vf_reg, out_vs_reg, out_w_reg;

    // combinational
    logic signed [32:0] sum_c, diff_c;
    logic [32:0]        dabs_c;
    logic [32:0]        rshift_c;
    logic               qbit_c;
    logic [31:0]        mag_c;
    logic signed [31:0] w_c;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod_c;
    logic [31:0]        ang_c;
    logic signed [32:0] x0_c, y0_c, qx_c, qy_c;
    logic signed [49:0] dx_c, dy_c;
    logic [31:0]        atan_c;
    logic signed [49:0] cxs_c, cys_c;
    logic signed [49:0] dpos_c, sumx_c, sumy_c;

    assign sum_c  = 33'(s_left_speed) + 33'(s_right_speed);
    assign diff_c = 33'(s_right_speed) - 33'(s_left_speed);
    assign dabs_c = diff_c[32] ? 33'(-diff_c) : 33'(diff_c);

    // restoring divider, one quotient bit per cycle
    assign rshift_c = {rem_reg, quo_reg[48]};
    assign qbit_c   = (rshift_c >= {1'b0, axle_length});

    always_comb begin
        mag_c = (quo_reg > 49'h80000000) ? 32'h80000000 : quo_reg[31:0];
        if (axle_length == '0) begin
            if (dzero_reg) begin
                w_c = '0;
            end else begin
                w_c = dneg_reg ? 32'sh80000000 : 32'sh7FFFFFFF;
            end
        end else if (dneg_reg) begin
            w_c = -$signed(mag_c);
        end else begin
            w_c = mag_c[31] ? 32'sh7FFFFFFF : $signed(mag_c);
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_MULW: begin mul_a = 34'(w_reg);            mul_b = $signed({10'b0, dt_reg}); end
            OP_MULL: begin mul_a = $signed({2'b0, prod_reg[31:0]}); mul_b = RAD_TO_BAM; end
            OP_MULH: begin mul_a = $signed({2'b0, ph_reg}); mul_b = RAD_TO_BAM; end
            OP_SCLX: begin mul_a = cx_reg[33:0];          mul_b = GAIN_Q31; end
            OP_SCLY: begin mul_a = cy_reg[33:0];          mul_b = GAIN_Q31; end
            OP_MDX:  begin mul_a = wx_reg;                mul_b = $signed({10'b0, dt_reg}); end
            OP_MDY:  begin mul_a = wy_reg;                mul_b = $signed({10'b0, dt_reg}); end
            default: begin mul_a = '0;                    mul_b = '0; end
        endcase
    end
    assign prod_c = mul_a * mul_b;

    // quadrant fold ahead of the CORDIC
    always_comb begin
        ang_c = cmd.phase ? pose_h_reg : dth_reg;
        x0_c  = cmd.phase ? 33'(vx_reg) : 33'(v_reg);
        y0_c  = cmd.phase ? 33'(vy_reg) : 33'sd0;
        unique case (ang_c[31:30])
            2'd1:    begin qx_c = -y0_c; qy_c = x0_c;  end
            2'd2:    begin qx_c = -x0_c; qy_c = -y0_c; end
            2'd3:    begin qx_c = y0_c;  qy_c = -x0_c; end
            default: begin qx_c = x0_c;  qy_c = y0_c;  end
        endcase
    end

    assign dx_c   = cy_reg >>> cmd.idx;
    assign dy_c   = cx_reg >>> cmd.idx;
    assign atan_c = atan_bam(cmd.idx);
    assign cxs_c  = cx_reg >>> 16;
    assign cys_c  = cy_reg >>> 16;

    assign dpos_c = prod_reg[65:16];
    assign sumx_c = 50'(pose_x_reg) + dpos_c;
    assign sumy_c = 50'(pose_y_reg) + dpos_c;

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                v_reg     <= sum_c[32:1];
                dneg_reg  <= diff_c[32];
                dzero_reg <= (diff_c == '0);
                dt_reg    <= s_elapsed_time;
                rem_reg   <= '0;
                quo_reg   <= {dabs_c, 16'b0};
            end
            OP_DIV: begin
                rem_reg <= qbit_c ? 32'(rshift_c - {1'b0, axle_length}) : rshift_c[31:0];
                quo_reg <= {quo_reg[47:0], qbit_c};
            end
            OP_WSAT: w_reg <= w_c;
            OP_MULW: prod_reg <= prod_c;
            OP_MULL: begin
                prod_reg <= prod_c;
                ph_reg   <= prod_reg[63:32];
            end
            OP_MULH: begin
                prod_reg <= prod_c;
                acc_reg  <= prod_reg[63:32];
            end
            OP_DTH: dth_reg <= prod_reg[31:0] + acc_reg;
            OP_RPRE: begin
                cx_reg <= 50'(qx_c);
                cy_reg <= 50'(qy_c);
                z_reg  <= $signed({4'b0, ang_c[29:0]});
            end
            OP_SCLX: prod_reg <= prod_c;
            OP_SCLY: begin
                prod_reg <= prod_c;
                cx_reg   <= prod_reg[64:15];
            end
            OP_SCLW: cy_reg <= prod_reg[64:15];
            OP_ROT: begin
                if (!z_reg[33]) begin
                    cx_reg <= cx_reg - dx_c;
                    cy_reg <= cy_reg + dy_c;
                    z_reg  <= z_reg - $signed({2'b0, atan_c});
                end else begin
                    cx_reg <= cx_reg + dx_c;
                    cy_reg <= cy_reg - dy_c;
                    z_reg  <= z_reg + $signed({2'b0, atan_c});
                end
            end
            OP_RPOST: begin
                if (!cmd.phase) begin
                    vx_reg <= sat32(cxs_c[33:0]);
                    vy_reg <= sat32(cys_c[33:0]);
                end else begin
                    wx_reg <= cxs_c[33:0];
                    wy_reg <= cys_c[33:0];
                end
            end
            OP_MDX: prod_reg <= prod_c;
            OP_MDY: begin
                prod_reg <= prod_c;
                nx_reg   <= sat48(sumx_c);
            end
            OP_DYWB: ny_reg <= sat48(sumy_c);
            OP_COMMIT: begin
                out_vf_reg <= vx_reg;
                out_vs_reg <= vy_reg;
                out_w_reg  <= w_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pose_x_reg <= '0;
            pose_y_reg <= '0;
            pose_h_reg <= '0;
        end else if (cmd.op == OP_COMMIT) begin
            pose_x_reg <= nx_reg;
            pose_y_reg <= ny_reg;
            pose_h_reg <= pose_h_reg + dth_reg;
        end
    end

    assign m_pos_x     = pose_x_reg;
    assign m_pos_y     = pose_y_reg;
    assign m_heading   = pose_h_reg;
    assign m_vel_fwd   = out_vf_reg;
    assign m_vel_side  = out_vs_reg;
    assign m_turn_rate = out_w_reg;

endmodule

// ----- rtl/diff_drive_odometry.sv -----
// Top level of the differential-drive odometry block: config register, sequencer, datapath.
`timescale 1ns / 1ps
// Dead-reckoning pose integrator. Each item (wheel speeds, elapsed time) yields one result
// with the updated x, y, heading and the body velocity and turn rate. One item is worked at
// a time: a new item is taken only after the last one is committed. The pace is set by the
// bit-serial 49-step turn-rate divider and by two passes of a single CORDIC unit, with one
// shared multiplier between them. A finished result waits in the output register while the
// next item is taken. axle_length sits at byte address 0.
module diff_drive_odometry import ddo_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_left_speed,
    input  logic signed [31:0] s_right_speed,
    input  logic [23:0]        s_elapsed_time,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [47:0] m_pos_x,
    output logic signed [47:0] m_pos_y,
    output logic [31:0]        m_heading,
    output logic signed [31:0] m_vel_fwd,
    output logic signed [31:0] m_vel_side,
    output logic signed [31:0] m_turn_rate
);

    logic [31:0] axle_reg;
    ddo_cmd_t    ctrl_cmd;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_AXLE);
    assign prdata  = reg_sel ? axle_reg : 32'h0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axle_reg <= AXLE_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            axle_reg <= pwdata;
        end
    end

    ddo_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (ctrl_cmd)
    );

    ddo_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (ctrl_cmd),
        .axle_length    (axle_reg),
        .s_left_speed   (s_left_speed),
        .s_right_speed  (s_right_speed),
        .s_elapsed_time (s_elapsed_time),
        .m_pos_x        (m_pos_x),
        .m_pos_y        (m_pos_y),
        .m_heading      (m_heading),
        .m_vel_fwd      (m_vel_fwd),
        .m_vel_side     (m_vel_side),
        .m_turn_rate    (m_turn_rate)
    );

    // pose only moves on a commit
    a_heading_on_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(m_heading) |-> $past(ctrl_cmd.op == OP_COMMIT))
        else $error("heading changed without a commit");

    // an accepted item cannot finish in the next cycle
    a_no_early_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (ctrl_cmd.op != OP_COMMIT))
        else $error("commit right after accept");

    // a commit always raises the output valid
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_cmd.op == OP_COMMIT) |=> m_valid)
        else $error("commit without output valid");

endmodule

// ----- verif/diff_drive_odometry_tb.sv -----
// Self-checking testbench for diff_drive_odometry: random-idle driver, monitor, pose predictor.
`timescale 1ns / 1ps
module diff_drive_odometry_tb;
    import ddo_pkg::*;

    localparam int STEPS = CORDIC_STEPS_DEF;
    localparam longint GAIN = 64'sd1304065748;
    localparam longint SPD_MAX = 64'sd2147483647;
    localparam longint SPD_MIN = -64'sd2147483648;
    localparam longint XY_MAX = 64'sd140737488355327;
    localparam longint XY_MIN = -64'sd140737488355328;
    localparam int SETTLE = 200;

    typedef struct {
        logic signed [31:0] left;
        logic signed [31:0] right;
        logic [23:0]        dt;
    } wheel_item_t;

    typedef struct {
        logic signed [47:0] x;
        logic signed [47:0] y;
        logic [31:0]        hd;
        logic signed [31:0] vf;
        logic signed [31:0] vs;
        logic signed [31:0] wr;
    } pose_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_left_speed = '0, s_right_speed = '0;
    logic [23:0] s_elapsed_time = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [47:0] m_pos_x, m_pos_y;
    logic [31:0] m_heading;
    logic signed [31:0] m_vel_fwd, m_vel_side, m_turn_rate;

    diff_drive_odometry u_top (.*);

    // predictor state
    logic [31:0] axle_q = AXLE_RESET;
    longint      est_x = 0, est_y = 0;
    logic [31:0] est_hd = '0;
    logic [31:0] atan_tab [32];

    wheel_item_t pend_items[$];
    pose_t       pose_expq[$];
    int          errs = 0;
    bit          item_taken = 0, pose_taken = 0;
    bit          no_gaps = 0;
    int          gap_left = 0, stall_left = 0;

    initial begin
        atan_tab = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
                     32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
                     32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
                     32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                     32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
                     32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
                     32'h00000001, 32'h00000000};
    end

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic longint clamp32(input longint v);
        if (v > SPD_MAX) return SPD_MAX;
        if (v < SPD_MIN) return SPD_MIN;
        return v;
    endfunction

    function automatic longint clamp48(input longint v);
        if (v > XY_MAX) return XY_MAX;
        if (v < XY_MIN) return XY_MIN;
        return v;
    endfunction

    // quadrant fold, gain prescale, then CORDIC with 16 guard bits
    function automatic void cordic_rotate(input longint xi, input longint yi,
                                          input logic [31:0] ang,
                                          output longint xo, output longint yo);
        longint x, y, z, t, dx, dy;
        x = xi;
        y = yi;
        z = longint'(ang[29:0]);
        case (ang[31:30])
            2'd1: begin t = x; x = -y; y = t; end
            2'd2: begin x = -x; y = -y; end
            2'd3: begin t = x; x = y; y = -t; end
            default: ;
        endcase
        x = (x * GAIN) >>> 15;
        y = (y * GAIN) >>> 15;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_tab[i]);
            end else begin
                x += dx; y -= dy; z += longint'(atan_tab[i]);
            end
        end
        xo = x >>> 16;
        yo = y >>> 16;
    endfunction

    function automatic pose_t integrate_pose(input wheel_item_t it);
        pose_t r;
        longint vl, vr, dt, v, diff, w, p, vx, vy, wx, wy;
        longint unsigned mag;
        logic [31:0] dth;
        vl = longint'(it.left);
        vr = longint'(it.right);
        dt = longint'({8'd0, it.dt});
        v = (vl + vr) >>> 1;
        diff = vr - vl;
        if (axle_q == 0) begin
            w = diff > 0 ? SPD_MAX : (diff < 0 ? SPD_MIN : 0);
        end else begin
            mag = longint'(diff < 0 ? -diff : diff) << 16;
            mag = mag / longint'({32'd0, axle_q});
            if (mag > 64'h80000000) mag = 64'h80000000;
            w = clamp32(diff < 0 ? -longint'(mag) : longint'(mag));
        end
        p = w * dt;
        dth = 32'((longint'(p) * 64'd683565276) >> 32);
        cordic_rotate(v, 0, dth, vx, vy);
        vx = clamp32(vx);
        vy = clamp32(vy);
        cordic_rotate(vx, vy, est_hd, wx, wy);
        est_x = clamp48(est_x + ((wx * dt) >>> 16));
        est_y = clamp48(est_y + ((wy * dt) >>> 16));
        est_hd = est_hd + dth;
        r.x = est_x[47:0];
        r.y = est_y[47:0];
        r.hd = est_hd;
        r.vf = vx[31:0];
        r.vs = vy[31:0];
        r.wr = w[31:0];
        return r;
    endfunction

    // driver
    always @(negedge aclk) begin
        wheel_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !item_taken) begin
            // hold until accepted
        end else if (gap_left > 0) begin
            gap_left--;
            s_valid <= 1'b0;
        end else if (pend_items.size() > 0) begin
            it = pend_items.pop_front();
            s_left_speed <= it.left;
            s_right_speed <= it.right;
            s_elapsed_time <= it.dt;
            s_valid <= 1'b1;
            gap_left = no_gaps ? 0 : $urandom_range(0, 6);
        end else begin
            s_valid <= 1'b0;
        end
        item_taken = 0;
    end

    always @(posedge aclk) begin
        wheel_item_t it;
        if (aresetn && s_valid && s_ready) begin
            it.left = s_left_speed;
            it.right = s_right_speed;
            it.dt = s_elapsed_time;
            pose_expq.push_back(integrate_pose(it));
            item_taken = 1;
        end
    end

    // result side: stall draw after each accepted result
    always @(negedge aclk) begin
        if (pose_taken) begin
            stall_left = no_gaps ? 0 : $urandom_range(0, 6);
            pose_taken = 0;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        pose_t e;
        if (aresetn && m_valid && m_ready) begin
            pose_taken = 1;
            if (pose_expq.size() == 0) begin
                $error("unexpected result item");
                errs++;
            end else begin
                e = pose_expq.pop_front();
                if (m_pos_x !== e.x) begin
                    $error("pos_x exp %0d got %0d", e.x, m_pos_x); errs++;
                end
                if (m_pos_y !== e.y) begin
                    $error("pos_y exp %0d got %0d", e.y, m_pos_y); errs++;
                end
                if (m_heading !== e.hd) begin
                    $error("heading exp %0h got %0h", e.hd, m_heading); errs++;
                end
                if (m_vel_fwd !== e.vf) begin
                    $error("vel_fwd exp %0d got %0d", e.vf, m_vel_fwd); errs++;
                end
                if (m_vel_side !== e.vs) begin
                    $error("vel_side exp %0d got %0d", e.vs, m_vel_side); errs++;
                end
                if (m_turn_rate !== e.wr) begin
                    $error("turn_rate exp %0d got %0d", e.wr, m_turn_rate); errs++;
                end
            end
        end
    end

    task automatic apb_write(input logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= PADDR_W'(REG_AXLE) << 2;
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        axle_q = val;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic add_item(input longint l, input longint r, input int unsigned dt);
        wheel_item_t it;
        it.left = l[31:0];
        it.right = r[31:0];
        it.dt = dt[23:0];
        pend_items.push_back(it);
    endtask

    task automatic drain();
        wait (pend_items.size() == 0 && !s_valid && pose_expq.size() == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic longint pick_speed();
        case ($urandom_range(0, 3))
            0: return longint'(signed'($urandom));
            1: return longint'($urandom_range(0, 1 << 20)) - (1 << 19);
            default: return longint'($urandom_range(0, 1 << 18)) - (1 << 17);
        endcase
    endfunction

    function automatic int unsigned pick_dt();
        case ($urandom_range(0, 3))
            0: return $urandom & 32'hFFFFFF;
            default: return $urandom_range(0, 8192);
        endcase
    endfunction

    task automatic random_burst(input int n);
        longint l;
        for (int i = 0; i < n; i++) begin
            l = pick_speed();
            // often a near-straight run: right close to left
            if ($urandom_range(0, 2) == 0)
                add_item(l, clamp32(l + longint'($urandom_range(0, 2048)) - 1024), pick_dt());
            else
                add_item(l, pick_speed(), pick_dt());
        end
    endtask

    initial begin
        logic [31:0] axles [6];
        axles = '{32'd1, 32'hFFFFFFFF, 32'd0, 32'd65536, 32'd1000, 32'd43909};
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed, reset axle length
        add_item(0, 0, 0);
        add_item(SPD_MAX, SPD_MAX, 24'hFFFFFF);
        add_item(SPD_MIN, SPD_MIN, 24'hFFFFFF);
        add_item(SPD_MIN, SPD_MAX, 24'h010000);
        add_item(SPD_MAX, SPD_MIN, 24'h010000);
        add_item(65536, 65536, 0);
        add_item(-65536, 65536, 24'h008000);
        add_item(65536, 131072, 24'h001000);
        add_item(-1, 0, 1);
        add_item(0, -1, 24'hFFFFFF);
        add_item(32'h55555555, -32'sh55555556, 24'hAAAAAA);
        add_item(-32'sh55555556, 32'h55555555, 24'h555555);
        add_item(SPD_MAX, SPD_MAX - 1, 24'h800000);
        random_burst(150);
        drain();

        for (int k = 0; k < 6; k++) begin
            apb_write(axles[k]);
            no_gaps = (k == 4);
            add_item(SPD_MIN, SPD_MAX, 24'hFFFFFF);
            add_item(100, 100, 24'h123456);
            add_item(200, -200, 0);
            random_burst(40);
            drain();
        end

        // drive the pose into both clamps
        apb_write(32'hFFFFFFFF);
        no_gaps = 1;
        for (int i = 0; i < 240; i++) add_item(SPD_MAX, SPD_MAX, 24'hFFFFFF);
        for (int i = 0; i < 480; i++) add_item(SPD_MIN, SPD_MIN, 24'hFFFFFF);
        drain();
        no_gaps = 0;
        apb_write(AXLE_RESET);
        random_burst(100);
        drain();

        if (errs == 0)
            $display("diff_drive_odometry test passed");
        else
            $display("diff_drive_odometry test failed");
        $finish;
    end

    initial begin
        #30ms;
        $display("diff_drive_odometry test failed");
        $finish;
    end

endmodule
